// File: src/ppa_pkg.sv
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared codes for the program page allocator: operations, status values and default sizes.
// ----------------------------------------------------------------------------
package ppa_pkg;

    // operation codes
    localparam logic [2:0] OP_EXEC  = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_HEAP  = 3'd2;
    localparam logic [2:0] OP_QUERY = 3'd3;
    localparam logic [2:0] OP_RDCHK = 3'd4;
    localparam logic [2:0] OP_WRCHK = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_KEY_EXIST = 3'd1;
    localparam logic [2:0] ST_NO_SLOT   = 3'd2;
    localparam logic [2:0] ST_NO_PAGES  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_HEAP_BIG  = 3'd5;
    localparam logic [2:0] ST_NOT_OWNED = 3'd6;

    // default sizes
    localparam int NUM_SLOTS_DEF = 127;
    localparam int NUM_PAGES_DEF = 511;
    localparam int MAX_PPS_DEF   = 64;
    localparam int PAGE_SHIFT    = 7;    // 128-byte pages
    localparam int HEAP_MAX      = 256;
    localparam int FIXED_BYTES   = 512;  // data plus stack

endpackage

// File: src/program_page_allocator.sv
// ----------------------------------------------------------------------------
// program_page_allocator
// Program slot table with first-fit page allocation over a page-used map.
// ----------------------------------------------------------------------------
// channel  dir  signals                     content
// s_       in   tvalid tready tdata[47:0]   one command beat
// m_       out  tvalid tready tdata[39:0]   status / query beats, tlast = last
//
// After reset a clearing pass zeroes the slot table and page map; no command
// is taken during it.
// A command first searches the slot table, one slot read a cycle; exec and
// heap add a free-page count and a first-fit sweep of the page map; free and
// access checks read one page-list entry a cycle; query reads one page-list
// entry for each page beat.
// A beat still waiting at the output holds the sequencer only when another
// beat is due; the input waits for the command in progress.
// ----------------------------------------------------------------------------
module program_page_allocator #(
    parameter int NUM_SLOTS          = ppa_pkg::NUM_SLOTS_DEF,
    parameter int NUM_PAGES          = ppa_pkg::NUM_PAGES_DEF,
    parameter int MAX_PAGES_PER_SLOT = ppa_pkg::MAX_PPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], prog_key[18:3], amount[31:19], address[47:32]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], total_bytes[15:3], page_address[31:16], segment[35:32]
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    import ppa_pkg::*;

    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW    = $clog2(NUM_PAGES);
    localparam int CW    = $clog2(MAX_PAGES_PER_SLOT + 1);
    localparam int LD    = NUM_SLOTS * MAX_PAGES_PER_SLOT;
    localparam int LAW   = (LD > 1) ? $clog2(LD) : 1;
    localparam int MAXN0 = (NUM_SLOTS > NUM_PAGES) ? NUM_SLOTS : NUM_PAGES;
    localparam int CLR_N = MAXN0;
    localparam int IW    = $clog2(MAXN0 + 1);
    localparam int FW    = $clog2(NUM_PAGES + 1);
    localparam int SLOTW = CW + 39;

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_LOOK  = 13'b0000000000100,
        S_DISP  = 13'b0000000001000,
        S_FCNT  = 13'b0000000010000,
        S_ALLOC = 13'b0000000100000,
        S_SLOTW = 13'b0000001000000,
        S_FREE  = 13'b0000010000000,
        S_OWN   = 13'b0000100000000,
        S_QRD   = 13'b0001000000000,
        S_QWAIT = 13'b0010000000000,
        S_QOUT  = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0]  cnt_reg, cnt_next, didx_reg, didx_next;
    logic           dv_reg, dv_next;
    logic [2:0]     op_reg, op_next;
    logic [15:0]    key_reg, key_next, addr_reg, addr_next;
    logic [12:0]    amt_reg, amt_next;
    logic           found_reg, found_next, freef_reg, freef_next, hit_reg, hit_next;
    logic [SW-1:0]  fslot_reg, fslot_next, freeslot_reg, freeslot_next;
    logic [SW-1:0]  tgt_reg, tgt_next;
    logic [12:0]    code_reg, code_next, total_reg, total_next;
    logic [8:0]     heap_reg, heap_next;
    logic [CW-1:0]  count_reg, count_next, have_reg, have_next, qi_reg, qi_next;
    logic [6:0]     need_reg, need_next;
    logic [FW-1:0]  fcnt_reg, fcnt_next;
    logic [PW-1:0]  qpage_reg, qpage_next;
    logic           mv_reg, mv_next, mlast_reg, mlast_next;
    logic [2:0]     mst_reg, mst_next;
    logic [2:0]     res_reg, res_next;
    logic [12:0]    mtot_reg, mtot_next;
    logic [15:0]    mpa_reg, mpa_next;

    // memory ports
    logic             slot_we, map_we, map_wd, list_we;
    logic [SW-1:0]    slot_wa, slot_ra;
    logic [SLOTW-1:0] slot_wd, slot_rd;
    logic [PW-1:0]    map_wa, map_ra, list_wd, list_rd;
    logic             map_rd;
    logic [LAW-1:0]   list_wa, list_ra;

    ppa_ram #(.WIDTH(SLOTW), .DEPTH(NUM_SLOTS)) u_slot (
        .aclk(aclk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
        .raddr(slot_ra), .rdata(slot_rd)
    );
    ppa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
        .raddr(map_ra), .rdata(map_rd)
    );
    ppa_ram #(.WIDTH(PW), .DEPTH(LD)) u_list (
        .aclk(aclk), .we(list_we), .waddr(list_wa), .wdata(list_wd),
        .raddr(list_ra), .rdata(list_rd)
    );

    // slot word fields
    logic          rd_valid;
    logic [15:0]   rd_key;
    logic [12:0]   rd_code;
    logic [8:0]    rd_heap;
    logic [CW-1:0] rd_count;
    assign rd_count = slot_rd[CW-1:0];
    assign rd_heap  = slot_rd[CW+8:CW];
    assign rd_code  = slot_rd[CW+21:CW+9];
    assign rd_key   = slot_rd[CW+37:CW+22];
    assign rd_valid = slot_rd[CW+38];

    logic [IW-1:0] lim;
    logic          scan_more, scan_done, out_free;
    logic [13:0]   need_sum;
    logic [13:0]   tot_sum;
    logic [7:0]    have_need;

    assign out_free  = !mv_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign scan_more = cnt_reg < lim;
    assign scan_done = !scan_more && !dv_reg;
    assign need_sum  = 14'(amt_reg) + 14'(FIXED_BYTES + 127);
    assign tot_sum   = 14'(code_reg) + 14'(FIXED_BYTES) + 14'(heap_reg);
    assign have_need = 8'(have_reg) + 8'(need_reg);

    // scan limit per state
    always_comb begin
        case (state_reg)
            S_LOOK:          lim = IW'(NUM_SLOTS);
            S_FCNT, S_ALLOC: lim = IW'(NUM_PAGES);
            S_FREE, S_OWN:   lim = IW'(count_reg);
            default:         lim = '0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg; dv_next = 1'b0; didx_next = didx_reg;
        op_next = op_reg; key_next = key_reg; amt_next = amt_reg; addr_next = addr_reg;
        found_next = found_reg; fslot_next = fslot_reg;
        freef_next = freef_reg; freeslot_next = freeslot_reg;
        code_next = code_reg; heap_next = heap_reg; count_next = count_reg;
        tgt_next = tgt_reg; have_next = have_reg; need_next = need_reg;
        fcnt_next = fcnt_reg; hit_next = hit_reg; qi_next = qi_reg;
        qpage_next = qpage_reg; total_next = total_reg; res_next = res_reg;
        mv_next = mv_reg && !m_tready; mst_next = mst_reg; mtot_next = mtot_reg;
        mpa_next = mpa_reg; mlast_next = mlast_reg;
        slot_we = 1'b0; slot_wa = cnt_reg[SW-1:0]; slot_wd = '0;
        slot_ra = cnt_reg[SW-1:0];
        map_we = 1'b0; map_wa = cnt_reg[PW-1:0]; map_wd = 1'b0;
        map_ra = cnt_reg[PW-1:0];
        list_we = 1'b0; list_wd = didx_reg[PW-1:0];
        list_wa = LAW'(32'(tgt_reg) * MAX_PAGES_PER_SLOT + 32'(have_reg));
        list_ra = LAW'(32'(tgt_reg) * MAX_PAGES_PER_SLOT + 32'(cnt_reg));

        // pipelined sweep: issue one read a cycle
        if ((state_reg & (S_LOOK | S_FCNT | S_ALLOC | S_FREE | S_OWN)) != '0
            && scan_more) begin
            dv_next   = 1'b1;
            didx_next = cnt_reg;
            cnt_next  = cnt_reg + 1'b1;
        end

        case (state_reg)
            S_CLR: begin
                slot_we = (32'(cnt_reg) < NUM_SLOTS);
                map_we  = (32'(cnt_reg) < NUM_PAGES);
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == CLR_N - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tdata[2:0];
                    key_next  = s_tdata[18:3];
                    amt_next  = s_tdata[31:19];
                    addr_next = s_tdata[47:32];
                    found_next = 1'b0; freef_next = 1'b0; hit_next = 1'b0;
                    cnt_next = '0;
                    if (s_tdata[2:0] <= OP_WRCHK) begin
                        state_next = S_LOOK;
                    end
                end
            end
            // slot search, lowest match and lowest free slot
            S_LOOK: begin
                if (dv_reg) begin
                    if (rd_valid && rd_key == key_reg && !found_reg) begin
                        found_next = 1'b1;
                        fslot_next = didx_reg[SW-1:0];
                        code_next  = rd_code;
                        heap_next  = rd_heap;
                        count_next = rd_count;
                    end
                    if (!rd_valid && !freef_reg) begin
                        freef_next    = 1'b1;
                        freeslot_next = didx_reg[SW-1:0];
                    end
                end
                if (scan_done) begin
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cnt_next = '0;
                fcnt_next = '0;
                res_next = ST_NOT_FOUND;
                state_next = S_RESP;
                case (op_reg)
                    OP_EXEC: begin
                        if (found_reg) begin
                            res_next = ST_KEY_EXIST;
                        end else if (!freef_reg) begin
                            res_next = ST_NO_SLOT;
                        end else begin
                            tgt_next = freeslot_reg;
                            have_next = '0;
                            need_next = 7'(need_sum >> PAGE_SHIFT) + 7'd4;
                            state_next = S_FCNT;
                        end
                    end
                    OP_FREE: begin
                        tgt_next = fslot_reg;
                        if (found_reg) state_next = S_FREE;
                    end
                    OP_HEAP: begin
                        if (amt_reg > 13'(HEAP_MAX)) begin
                            res_next = ST_HEAP_BIG;
                        end else if (found_reg) begin
                            tgt_next = fslot_reg;
                            have_next = count_reg;
                            need_next = 7'((14'(amt_reg) + 14'd127) >> PAGE_SHIFT);
                            state_next = S_FCNT;
                        end
                    end
                    OP_QUERY: begin
                        tgt_next = fslot_reg;
                        qi_next = '0;
                        total_next = (tot_sum > 14'd8191) ? 13'd8191 : 13'(tot_sum);
                        if (found_reg) state_next = S_QRD;
                    end
                    default: begin
                        tgt_next = fslot_reg;
                        if (found_reg) state_next = S_OWN;
                    end
                endcase
            end
            // count free pages
            S_FCNT: begin
                if (dv_reg && !map_rd) fcnt_next = fcnt_reg + 1'b1;
                if (scan_done) begin
                    cnt_next = '0;
                    if (9'(need_reg) > 9'(fcnt_reg)
                        || 32'(have_need) > MAX_PAGES_PER_SLOT) begin
                        res_next = ST_NO_PAGES;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_ALLOC;
                    end
                end
            end
            // take lowest free pages
            S_ALLOC: begin
                if (need_reg == '0) begin
                    state_next = S_SLOTW;
                end else if (dv_reg && !map_rd) begin
                    map_we = 1'b1; map_wa = didx_reg[PW-1:0]; map_wd = 1'b1;
                    list_we = 1'b1;
                    have_next = have_reg + 1'b1;
                    need_next = need_reg - 1'b1;
                end
            end
            S_SLOTW: begin
                slot_we = 1'b1;
                slot_wa = tgt_reg;
                if (op_reg == OP_EXEC) begin
                    slot_wd = {1'b1, key_reg, amt_reg, 9'd0, have_reg};
                end else begin
                    slot_wd = {1'b1, key_reg, code_reg, amt_reg[8:0], have_reg};
                end
                res_next = ST_OK;
                state_next = S_RESP;
            end
            // release owned pages, then clear the slot
            S_FREE: begin
                if (dv_reg && 32'(list_rd) < NUM_PAGES) begin
                    map_we = 1'b1; map_wa = list_rd; map_wd = 1'b0;
                end
                if (scan_done) begin
                    slot_we = 1'b1; slot_wa = tgt_reg; slot_wd = '0;
                    res_next = ST_OK;
                    state_next = S_RESP;
                end
            end
            S_OWN: begin
                if (dv_reg && (32'(list_rd) << PAGE_SHIFT) == 32'(addr_reg)) begin
                    hit_next = 1'b1;
                end
                if (scan_done) begin
                    res_next = hit_reg ? ST_OK : ST_NOT_OWNED;
                    state_next = S_RESP;
                end
            end
            S_QRD: begin
                list_ra = LAW'(32'(tgt_reg) * MAX_PAGES_PER_SLOT + 32'(qi_reg));
                state_next = S_QWAIT;
            end
            S_QWAIT: begin
                qpage_next = list_rd;
                state_next = S_QOUT;
            end
            // one beat per owned page, or a single beat when none
            S_QOUT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    mst_next = ST_OK;
                    mtot_next = total_reg;
                    mpa_next = (count_reg == '0) ? 16'd0 : 16'(32'(qpage_reg) << PAGE_SHIFT);
                    mlast_next = (count_reg == '0) || (qi_reg + 1'b1 == count_reg);
                    qi_next = qi_reg + 1'b1;
                    state_next = ((count_reg == '0) || (qi_reg + 1'b1 == count_reg))
                                 ? S_IDLE : S_QRD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    mst_next = res_reg;
                    mtot_next = '0;
                    mpa_next = '0;
                    mlast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dv_reg    <= dv_next;
            mv_reg    <= mv_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        didx_reg <= didx_next; op_reg <= op_next; key_reg <= key_next;
        amt_reg <= amt_next; addr_reg <= addr_next; found_reg <= found_next;
        fslot_reg <= fslot_next; freef_reg <= freef_next; freeslot_reg <= freeslot_next;
        code_reg <= code_next; heap_reg <= heap_next; count_reg <= count_next;
        tgt_reg <= tgt_next; have_reg <= have_next; need_reg <= need_next;
        fcnt_reg <= fcnt_next; hit_reg <= hit_next; qi_reg <= qi_next;
        qpage_reg <= qpage_next; total_reg <= total_next; res_reg <= res_next;
        mst_reg <= mst_next; mtot_reg <= mtot_next; mpa_reg <= mpa_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {4'd0, mpa_reg[15:12], mpa_reg, mtot_reg, mst_reg};

    // checks
    a_have_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC) |-> (32'(have_reg) <= MAX_PAGES_PER_SLOT))
        else $error("page list overrun");
    a_fcnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FCNT) |-> (32'(fcnt_reg) <= NUM_PAGES))
        else $error("free count overrun");
    a_bad_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[2:0] > OP_WRCHK) |=> (state_reg == S_IDLE))
        else $error("unused op started work");
    a_no_beat_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !mv_reg)
        else $error("result during clearing pass");

endmodule

// File: src/ppa_ram.sv
// ----------------------------------------------------------------------------
// ppa_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, old data on collision
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
